>>> hdl/dph_pkg.sv
// Shared types, register map and constants for the straight-drive PID controller.
package dph_pkg;

    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;

    typedef enum logic [2:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_GAIN_HEADING  = 3'd3,
        REG_MAX_POWER     = 3'd4,
        REG_INTEGRAL_ZONE = 3'd5,
        REG_TUNE_LIMIT    = 3'd6,
        REG_NONE          = 3'd7
    } reg_index_t;

    localparam logic [15:0] GAIN_P_RESET        = 16'd3277;
    localparam logic [15:0] GAIN_I_RESET        = 16'd41;
    localparam logic [15:0] GAIN_D_RESET        = 16'd1434;
    localparam logic [15:0] GAIN_HEADING_RESET  = 16'd12288;
    localparam logic [9:0]  MAX_POWER_RESET     = 10'd500;
    localparam logic [15:0] INTEGRAL_ZONE_RESET = 16'd100;
    localparam logic [9:0]  TUNE_LIMIT_RESET    = 10'd100;

    localparam int          FullTurn     = 36000;
    localparam int          HalfTurn     = 18000;
    localparam logic [38:0] INTEGRAL_MAX = {39{1'b1}};
    // ceil(2^22 / 25): exact quotient by 25 for dividends below 2^17
    localparam logic [17:0] RECIP_25     = 18'd167773;
    localparam logic [55:0] ROUND_BIAS   = 56'd8191;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] gain_heading;
        logic [9:0]  max_power;
        logic [15:0] integral_zone;
        logic [9:0]  tune_limit;
    } cfg_t;

    typedef struct packed {
        logic               zero;
        logic               done;
        logic               dir;
        logic [16:0]        err;
        logic signed [17:0] deriv;
        logic [38:0]        integ;
        logic signed [15:0] wrap;
    } trk_t;

endpackage

>>> hdl/dph_if.sv
// Handshake channels for command words and drive result words.
interface dph_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [16:0] target_distance;
    logic signed [20:0] left_count;
    logic signed [20:0] right_count;
    logic signed [16:0] heading;

    modport source (output valid, kind, target_distance, left_count, right_count, heading,
                    input ready);
    modport sink   (input valid, kind, target_distance, left_count, right_count, heading,
                    output ready);
endinterface

interface dph_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] left_velocity;
    logic signed [11:0] right_velocity;
    logic               done_res;

    modport source (output valid, left_velocity, right_velocity, done_res, input ready);
    modport sink   (input valid, left_velocity, right_velocity, done_res, output ready);
endinterface

>>> hdl/drive_pid_with_heading_hold.sv
// Top level of the straight-drive PID controller with heading hold.
// Takes one command word per clock while the result side takes words, and returns one drive
// word per command, in order. The edge that takes a command loads the input register, then
// follow the tracking stage (distance, error, integral and move state), the product stage,
// the sum stage and the result register. All five stages advance independently and fill
// bubbles, so the block sustains one word per cycle while the result side keeps taking words.
// Gains and limits sit in APB registers at byte addresses 0 to 24 and should change only while
// no word is in flight.
module drive_pid_with_heading_hold
    import dph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    dph_in_if.sink               cmd,
    dph_out_if.source            drive
);

    cfg_t cfg;
    trk_t trk;
    logic trk_valid;
    logic trk_ready;

    dph_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dph_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .trk_valid (trk_valid),
        .trk_ready (trk_ready),
        .trk       (trk)
    );

    dph_math u_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .trk_valid (trk_valid),
        .trk_ready (trk_ready),
        .trk       (trk),
        .drive     (drive)
    );

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid && drive.done_res |->
            drive.left_velocity == 12'sd0 && drive.right_velocity == 12'sd0)
        else $error("done word carries non-zero velocity");

    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        drive.ready |-> cmd.ready)
        else $error("command side stalled while result side is free");

    a_even_split: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |-> drive.left_velocity[0] == drive.right_velocity[0])
        else $error("left and right velocities differ by an odd amount");

endmodule

>>> hdl/dph_regs.sv
// APB configuration registers for gains and limits.
module dph_regs
    import dph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[AddrWidth-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_P:        cfg_next.gain_p        = pwdata[15:0];
                REG_GAIN_I:        cfg_next.gain_i        = pwdata[15:0];
                REG_GAIN_D:        cfg_next.gain_d        = pwdata[15:0];
                REG_GAIN_HEADING:  cfg_next.gain_heading  = pwdata[15:0];
                REG_MAX_POWER:     cfg_next.max_power     = pwdata[9:0];
                REG_INTEGRAL_ZONE: cfg_next.integral_zone = pwdata[15:0];
                REG_TUNE_LIMIT:    cfg_next.tune_limit    = pwdata[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_P:        prdata = {16'd0, cfg_reg.gain_p};
            REG_GAIN_I:        prdata = {16'd0, cfg_reg.gain_i};
            REG_GAIN_D:        prdata = {16'd0, cfg_reg.gain_d};
            REG_GAIN_HEADING:  prdata = {16'd0, cfg_reg.gain_heading};
            REG_MAX_POWER:     prdata = {22'd0, cfg_reg.max_power};
            REG_INTEGRAL_ZONE: prdata = {16'd0, cfg_reg.integral_zone};
            REG_TUNE_LIMIT:    prdata = {22'd0, cfg_reg.tune_limit};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= GAIN_P_RESET;
            cfg_reg.gain_i        <= GAIN_I_RESET;
            cfg_reg.gain_d        <= GAIN_D_RESET;
            cfg_reg.gain_heading  <= GAIN_HEADING_RESET;
            cfg_reg.max_power     <= MAX_POWER_RESET;
            cfg_reg.integral_zone <= INTEGRAL_ZONE_RESET;
            cfg_reg.tune_limit    <= TUNE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/dph_track.sv
// Input register and move tracking: distance, error, derivative, integral, heading wrap.
module dph_track
    import dph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    dph_in_if.sink     cmd,
    output logic       trk_valid,
    input  logic       trk_ready,
    output trk_t       trk
);

    localparam logic signed [19:0] HALF_W     = 20'sd18000;
    localparam logic signed [19:0] NEG_HALF_W = -20'sd18000;

    // input register
    logic               v0_reg;
    logic               kind_reg;
    logic signed [16:0] tgt_reg;
    logic signed [20:0] lc_reg;
    logic signed [20:0] rc_reg;
    logic signed [16:0] hd_reg;

    // move state
    logic [15:0]        tmag_reg, tmag_next;
    logic               dir_reg, dir_next;
    logic signed [16:0] sh_reg, sh_next;
    logic [16:0]        last_err_reg, last_err_next;
    logic [38:0]        integ_reg, integ_next;
    logic               first_reg, first_next;
    logic               active_reg, active_next;

    logic               v1_reg;
    trk_t               trk_reg, trk_next;

    logic               ld0, ld1, step;
    logic [16:0]        t_abs;
    logic [20:0]        l_abs, r_abs;
    logic [21:0]        dist_sum;
    logic [16:0]        tgt2;
    logic [16:0]        err;
    logic [39:0]        integ_sum;
    logic signed [19:0] ang;
    logic signed [19:0] cand;
    logic signed [15:0] wrap;

    assign ld1       = !v1_reg || trk_ready;
    assign ld0       = !v0_reg || ld1;
    assign step      = v0_reg && ld1;
    assign cmd.ready = ld0;
    assign trk_valid = v1_reg;
    assign trk       = trk_reg;

    always_comb
    begin
        t_abs     = tgt_reg[16] ? 17'(-tgt_reg) : 17'(tgt_reg);
        l_abs     = lc_reg[20] ? 21'(-lc_reg) : 21'(lc_reg);
        r_abs     = rc_reg[20] ? 21'(-rc_reg) : 21'(rc_reg);
        dist_sum  = {1'b0, l_abs} + {1'b0, r_abs};
        tgt2      = {tmag_reg, 1'b0};
        err       = 17'({5'd0, tgt2} - dist_sum);
        integ_sum = {1'b0, integ_reg} + {23'd0, err};
    end

    // wrap the heading error into (-180, 180] degrees
    always_comb
    begin
        ang  = 20'(sh_reg) - 20'(hd_reg);
        wrap = '0;
        cand = '0;
        for (int k = -4; k <= 4; k++)
        begin
            cand = ang + 20'(k * FullTurn);
            if (cand > NEG_HALF_W && cand <= HALF_W)
            begin
                wrap = cand[15:0];
            end
        end
    end

    always_comb
    begin
        tmag_next      = tmag_reg;
        dir_next       = dir_reg;
        sh_next        = sh_reg;
        last_err_next  = last_err_reg;
        integ_next     = integ_reg;
        first_next     = first_reg;
        active_next    = active_reg;
        trk_next.zero  = 1'b1;
        trk_next.done  = 1'b1;
        trk_next.dir   = dir_reg;
        trk_next.err   = err;
        trk_next.deriv = '0;
        trk_next.integ = integ_reg;
        trk_next.wrap  = wrap;
        if (!kind_reg)
        begin
            tmag_next     = t_abs[16] ? 16'hFFFF : t_abs[15:0];
            dir_next      = tgt_reg[16];
            sh_next       = hd_reg;
            last_err_next = '0;
            integ_next    = '0;
            first_next    = 1'b1;
            active_next   = (t_abs != '0);
            trk_next.done = (t_abs == '0);
        end
        else if (active_reg)
        begin
            if (dist_sum >= {5'd0, tgt2})
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (!first_reg)
                begin
                    trk_next.deriv = 18'($signed({1'b0, err}) - $signed({1'b0, last_err_reg}));
                end
                if (err < {cfg.integral_zone, 1'b0})
                begin
                    integ_next = integ_sum[39] ? INTEGRAL_MAX : integ_sum[38:0];
                end
                last_err_next  = err;
                first_next     = 1'b0;
                trk_next.zero  = 1'b0;
                trk_next.done  = 1'b0;
                trk_next.integ = integ_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            tmag_reg     <= '0;
            dir_reg      <= 1'b0;
            sh_reg       <= '0;
            last_err_reg <= '0;
            integ_reg    <= '0;
            first_reg    <= 1'b1;
            active_reg   <= 1'b0;
        end
        else
        begin
            if (ld0)
            begin
                v0_reg <= cmd.valid;
            end
            if (ld1)
            begin
                v1_reg <= v0_reg;
            end
            if (step)
            begin
                tmag_reg     <= tmag_next;
                dir_reg      <= dir_next;
                sh_reg       <= sh_next;
                last_err_reg <= last_err_next;
                integ_reg    <= integ_next;
                first_reg    <= first_next;
                active_reg   <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0 && cmd.valid)
        begin
            kind_reg <= cmd.kind;
            tgt_reg  <= cmd.target_distance;
            lc_reg   <= cmd.left_count;
            rc_reg   <= cmd.right_count;
            hd_reg   <= cmd.heading;
        end
        if (step)
        begin
            trk_reg <= trk_next;
        end
    end

endmodule

>>> hdl/dph_math.sv
// PID and heading-correction arithmetic pipeline with saturation and result register.
module dph_math
    import dph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       trk_valid,
    output logic       trk_ready,
    input  trk_t       trk,
    dph_out_if.source  drive
);

    // products
    logic               v2_reg;
    logic               zero2_reg, done2_reg, dir2_reg;
    logic [32:0]        pe_reg;
    logic signed [34:0] pd_reg;
    logic [35:0]        pil_reg;
    logic [34:0]        pih_reg;
    logic signed [32:0] ph_reg;

    // sums
    logic               v3_reg;
    logic               zero3_reg, done3_reg, dir3_reg;
    logic signed [56:0] acc_reg, acc_next;
    logic               tneg_reg;
    logic [11:0]        tq_reg, tq_next;

    // result
    logic               v4_reg;
    logic signed [11:0] lv_reg, lv_next;
    logic signed [11:0] rv_reg, rv_next;
    logic               done4_reg;

    logic               ld2, ld3, ld4;
    logic [31:0]        h_mag;
    logic [34:0]        tq_prod;
    logic signed [56:0] acc_bias;
    logic signed [43:0] pw, pw_dir;
    logic signed [43:0] mp;
    logic signed [10:0] power;
    logic signed [12:0] ts;
    logic signed [12:0] tl;
    logic signed [10:0] tune;

    assign ld4         = !v4_reg || drive.ready;
    assign ld3         = !v3_reg || ld4;
    assign ld2         = !v2_reg || ld3;
    assign trk_ready   = ld2;
    assign drive.valid          = v4_reg;
    assign drive.left_velocity  = lv_reg;
    assign drive.right_velocity = rv_reg;
    assign drive.done_res       = done4_reg;

    always_comb
    begin
        acc_next = $signed({24'd0, pe_reg}) + $signed({{22{pd_reg[34]}}, pd_reg})
                 + $signed({21'd0, pil_reg}) + $signed({2'd0, pih_reg, 20'd0});
        h_mag    = ph_reg[32] ? 32'(-ph_reg) : 32'(ph_reg);
        tq_prod  = 35'(h_mag[30:14]) * 35'(RECIP_25);
        tq_next  = tq_prod[33:22];
    end

    always_comb
    begin
        acc_bias = acc_reg + (acc_reg[56] ? $signed({1'b0, ROUND_BIAS}) : 57'sd0);
        pw       = 44'(acc_bias >>> 13);
        pw_dir   = dir3_reg ? -pw : pw;
        mp       = $signed({34'd0, cfg.max_power});
        if (pw_dir > mp)
        begin
            power = 11'(mp);
        end
        else if (pw_dir < -mp)
        begin
            power = 11'(-mp);
        end
        else
        begin
            power = 11'(pw_dir);
        end
        ts = tneg_reg ? -$signed({1'b0, tq_reg}) : $signed({1'b0, tq_reg});
        tl = $signed({3'd0, cfg.tune_limit});
        if (ts > tl)
        begin
            tune = 11'(tl);
        end
        else if (ts < -tl)
        begin
            tune = 11'(-tl);
        end
        else
        begin
            tune = 11'(ts);
        end
        lv_next = zero3_reg ? 12'sd0 : 12'(12'(power) + 12'(tune));
        rv_next = zero3_reg ? 12'sd0 : 12'(12'(power) - 12'(tune));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld2)
            begin
                v2_reg <= trk_valid;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && trk_valid)
        begin
            zero2_reg <= trk.zero;
            done2_reg <= trk.done;
            dir2_reg  <= trk.dir;
            pe_reg    <= 33'(cfg.gain_p) * 33'(trk.err);
            pd_reg    <= 35'($signed({1'b0, cfg.gain_d})) * 35'(trk.deriv);
            pil_reg   <= 36'(cfg.gain_i) * 36'(trk.integ[19:0]);
            pih_reg   <= 35'(cfg.gain_i) * 35'(trk.integ[38:20]);
            ph_reg    <= 33'($signed({1'b0, cfg.gain_heading})) * 33'(trk.wrap);
        end
        if (ld3 && v2_reg)
        begin
            zero3_reg <= zero2_reg;
            done3_reg <= done2_reg;
            dir3_reg  <= dir2_reg;
            acc_reg   <= acc_next;
            tneg_reg  <= ph_reg[32];
            tq_reg    <= tq_next;
        end
        if (ld4 && v3_reg)
        begin
            lv_reg    <= lv_next;
            rv_reg    <= rv_next;
            done4_reg <= done3_reg;
        end
    end

endmodule
